// File: rtl/ntoe_pkg.sv
// ----------------------------------------------------------------------------
// ntoe_pkg
// Shared types and constants for the neighbor table with oldest-entry
// replacement: transaction structs, table entry layout, outcome and
// register codes.
// ----------------------------------------------------------------------------
package ntoe_pkg;

    localparam int NTOE_TABLE_DEPTH = 8;

    localparam int NODE_W  = 8;
    localparam int VER_W   = 8;
    localparam int TIME_W  = 32;
    localparam int DATA_W  = 64;
    localparam int RIDX_W  = 3;
    localparam int OUT_W   = 3;
    localparam int ECNT_W  = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 1'b1;

    // Outcome codes
    localparam logic [OUT_W-1:0] OUT_BAD_LENGTH  = 3'd0;
    localparam logic [OUT_W-1:0] OUT_OWN_ID      = 3'd1;
    localparam logic [OUT_W-1:0] OUT_BAD_VERSION = 3'd2;
    localparam logic [OUT_W-1:0] OUT_UPDATED     = 3'd3;
    localparam logic [OUT_W-1:0] OUT_INSERTED    = 3'd4;
    localparam logic [OUT_W-1:0] OUT_REPLACED    = 3'd5;
    localparam logic [OUT_W-1:0] OUT_READ        = 3'd6;

    // Function codes
    localparam logic FUNC_RECEIVE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef struct packed {
        logic              func;
        logic              length_ok;
        logic [NODE_W-1:0] packet_node_id;
        logic [VER_W-1:0]  packet_version;
        logic [TIME_W-1:0] packet_timestamp;
        logic [DATA_W-1:0] packet_payload;
        logic [RIDX_W-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]  outcome;
        logic [RIDX_W-1:0] entry_index;
        logic [ECNT_W-1:0] entry_count;
        logic              read_valid;
        logic [NODE_W-1:0] read_node_id;
        logic [TIME_W-1:0] read_timestamp;
        logic [DATA_W-1:0] read_payload;
    } out_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] stamp;
        logic [DATA_W-1:0] data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/ntoe_ram.sv
// ----------------------------------------------------------------------------
// ntoe_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Contents are not reset.
// ----------------------------------------------------------------------------
module ntoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/neighbor_table_oldest_evict_core.sv
// Sequence: a dropped packet or a read beyond the count gives its result in the
//   cycle after accept; a valid read passes ST_READ; a receive visits ST_SCAN_RD
//   and ST_SCAN_CMP per entry scanned (filled count, fewer when a node ID match
//   ends the scan), then ST_WRITE; no stalls, results never wait, one at a time.
// Reset: filled count cleared, local_node_id = 0, expected_version = 1;
//   table RAM is not cleared, entries past the count are never exposed.
// ----------------------------------------------------------------------------
// neighbor_table_oldest_evict_core
// Neighbor table kept in one RAM. Receive transactions that pass the checks
// scan the filled entries for a matching node ID while tracking the oldest
// timestamp, then update, append or replace. Read transactions return one entry.
// ----------------------------------------------------------------------------
module neighbor_table_oldest_evict_core
    import ntoe_pkg::*;
#(
    parameter int TABLE_DEPTH = NTOE_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             request,
    output logic                 done,
    output out_item_t            response,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CMP = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;

    logic [2:0]        state_reg, state_next;
    in_item_t          req_reg, req_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [TIME_W-1:0] min_time_reg, min_time_next;
    logic [OUT_W-1:0]  op_reg, op_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NODE_W-1:0] local_id_reg;
    logic [VER_W-1:0]  exp_ver_reg;
    out_item_t         result_reg, result_next;
    logic              done_reg, done_next;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wentry;
    logic [ENTRY_W-1:0] ram_rvec;
    entry_t            ram_rentry;

    logic              accept;
    logic              read_hit;
    logic              last_entry;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign response  = result_reg;

    assign ram_rentry = entry_t'(ram_rvec);
    assign read_hit   = CMP_W'(request.read_index) < CMP_W'(count_reg);
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    ntoe_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ENTRY_W'(ram_wentry)),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rvec)
    );

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        min_idx_next  = min_idx_reg;
        min_time_next = min_time_reg;
        op_next       = op_reg;
        count_next    = count_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = slot_reg;
        ram_raddr     = idx_reg;
        ram_wentry    = '{node: req_reg.packet_node_id, stamp: req_reg.packet_timestamp,
                          data: req_reg.packet_payload};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next    = request;
                    idx_next    = '0;
                    result_next = '0;
                    result_next.entry_count = ECNT_W'(count_reg);
                    if (request.func == FUNC_READ)
                    begin
                        result_next.outcome     = OUT_READ;
                        result_next.entry_index = request.read_index;
                        if (read_hit)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = IDX_W'(request.read_index);
                            state_next = ST_READ;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if (!request.length_ok)
                        begin
                            result_next.outcome = OUT_BAD_LENGTH;
                            done_next = 1'b1;
                        end
                        else if (request.packet_node_id == local_id_reg)
                        begin
                            result_next.outcome = OUT_OWN_ID;
                            done_next = 1'b1;
                        end
                        else if (request.packet_version != exp_ver_reg)
                        begin
                            result_next.outcome = OUT_BAD_VERSION;
                            done_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            slot_next  = '0;
                            op_next    = OUT_INSERTED;
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                end
            end

            ST_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (ram_rentry.node == req_reg.packet_node_id)
                begin
                    slot_next  = idx_reg;
                    op_next    = OUT_UPDATED;
                    state_next = ST_WRITE;
                end
                else
                begin
                    // strict compare keeps the lowest index on a tie
                    if ((idx_reg == '0) || (ram_rentry.stamp < min_time_reg))
                    begin
                        min_time_next = ram_rentry.stamp;
                        min_idx_next  = idx_reg;
                    end
                    if (last_entry)
                    begin
                        if (count_reg < FULL_COUNT)
                        begin
                            slot_next = IDX_W'(count_reg);
                            op_next   = OUT_INSERTED;
                        end
                        else
                        begin
                            slot_next = min_idx_next;
                            op_next   = OUT_REPLACED;
                        end
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (op_reg == OUT_INSERTED)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                result_next.outcome     = op_reg;
                result_next.entry_index = RIDX_W'(slot_reg);
                result_next.entry_count = ECNT_W'(count_next);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_READ:
            begin
                result_next.read_valid     = 1'b1;
                result_next.read_node_id   = ram_rentry.node;
                result_next.read_timestamp = ram_rentry.stamp;
                result_next.read_payload   = ram_rentry.data;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            local_id_reg <= '0;
            exp_ver_reg  <= 8'd1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LOCAL_NODE_ID:    local_id_reg <= cfg_data;
                    CFG_EXPECTED_VERSION: exp_ver_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        slot_reg     <= slot_next;
        min_idx_reg  <= min_idx_next;
        min_time_reg <= min_time_next;
        op_reg       <= op_next;
        result_reg   <= result_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("filled count exceeds table depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (CNT_W'(ram_raddr) < count_reg))
        else $error("table read beyond filled entries");

    a_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> done_reg)
        else $error("table write without a result");

    a_count_grows_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (done_reg && (result_reg.outcome == OUT_INSERTED)
             && (count_reg == $past(count_reg) + CNT_W'(1))))
        else $error("filled count changed without an insert");

    a_insert_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.outcome == OUT_INSERTED)) |->
            (result_reg.entry_index == RIDX_W'(result_reg.entry_count - ECNT_W'(1))))
        else $error("inserted entry not at the end of the table");
`endif

endmodule
